// ===== sv/btiu_pkg.sv =====
// Shared types and constants for the busy-time interval union block.
package btiu_pkg;

    localparam int TIME_W        = 64;
    localparam int MAX_INTERVALS = 16;
    localparam int Q_DEPTH       = 2;

    typedef logic [TIME_W-1:0] t_time;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        t_time submit;
        t_time start;
        t_time stop;
        logic  ins_start;
        logic  ins_exec;
        logic  last;
    } t_item;

endpackage

// ===== sv/btiu_front.sv =====
// Front part: accepts beats and classifies which intervals to insert.
module btiu_front (
    input  logic             i_valid,
    output logic             o_ready,
    input  btiu_pkg::t_time  i_submit_time,
    input  btiu_pkg::t_time  i_start_time,
    input  btiu_pkg::t_time  i_end_time,
    input  logic             i_profiled,
    input  logic             i_last_event,
    input  logic             i_full,
    output logic             o_push,
    output btiu_pkg::t_item  o_item
);

    assign o_ready = !i_full;

    // Drop beats that are neither profiled nor close a batch.
    assign o_push = i_valid && !i_full && (i_profiled || i_last_event);

    always_comb begin
        o_item.submit    = i_submit_time;
        o_item.start     = i_start_time;
        o_item.stop      = i_end_time;
        // Inverted intervals cover nothing: skip them here.
        o_item.ins_start = i_profiled && (i_start_time >= i_submit_time);
        o_item.ins_exec  = i_profiled && (i_end_time >= i_start_time);
        o_item.last      = i_last_event;
    end

endmodule

// ===== sv/btiu_queue.sv =====
// Short queue of classified commands between the front and the back.
module btiu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  btiu_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output btiu_pkg::t_item  o_item
);

    localparam int QAW = (btiu_pkg::Q_DEPTH > 1) ? $clog2(btiu_pkg::Q_DEPTH) : 1;
    localparam int QCW = $clog2(btiu_pkg::Q_DEPTH + 1);
    localparam logic [QAW-1:0] LAST_PTR = QAW'(btiu_pkg::Q_DEPTH - 1);
    localparam logic [QCW-1:0] FULL_CNT = QCW'(btiu_pkg::Q_DEPTH);

    btiu_pkg::t_item r_slot [btiu_pkg::Q_DEPTH];
    logic [QAW-1:0]  r_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr;
    logic [QCW-1:0]  r_cnt;
    logic [QAW-1:0]  n_wr_ptr;
    logic [QAW-1:0]  n_rd_ptr;
    logic [QCW-1:0]  n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + QAW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + QAW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");

endmodule

// ===== sv/btiu_back.sv =====
// Back part: merges intervals into the stage tables and sums the covered length.
module btiu_back #(
    parameter int MAX_INTERVALS = btiu_pkg::MAX_INTERVALS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  btiu_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output btiu_pkg::t_time  o_starting_total,
    output btiu_pkg::t_time  o_executing_total,
    output logic             o_table_overflow
);

    localparam int IW    = $clog2(MAX_INTERVALS);
    localparam int CW    = $clog2(MAX_INTERVALS + 1);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_PLACE,
        S_SUM_SETUP,
        S_SUM,
        S_OUT
    } t_state;

    // Both stage tables share one memory; the stage selects the upper half.
    btiu_pkg::t_time m_lo [DEPTH];
    btiu_pkg::t_time m_hi [DEPTH];

    t_state          r_state, n_state;
    btiu_pkg::t_item r_item, n_item;
    logic            r_stage, n_stage;
    logic [CW-1:0]   r_count_s, n_count_s;
    logic [CW-1:0]   r_count_e, n_count_e;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_w, n_w;
    btiu_pkg::t_time r_lo, n_lo;
    btiu_pkg::t_time r_hi, n_hi;
    logic            r_hit, n_hit;
    logic            r_rdv, n_rdv;
    logic            r_dv, n_dv;
    btiu_pkg::t_time r_diff, n_diff;
    btiu_pkg::t_time r_acc_s, n_acc_s;
    btiu_pkg::t_time r_acc_e, n_acc_e;
    logic            r_ovf, n_ovf;
    logic            r_out_valid, n_out_valid;
    btiu_pkg::t_time r_out_s, n_out_s;
    btiu_pkg::t_time r_out_e, n_out_e;
    logic            r_out_ovf, n_out_ovf;
    btiu_pkg::t_time r_rd_lo;
    btiu_pkg::t_time r_rd_hi;

    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    btiu_pkg::t_time mem_wlo;
    btiu_pkg::t_time mem_whi;

    btiu_pkg::t_time cur_a;
    btiu_pkg::t_time cur_b;
    logic            cur_ins;
    logic [CW-1:0]   cur_count;
    logic            overlap;
    t_state          adv_state;
    logic            load_out;

    assign cur_a     = r_stage ? r_item.start : r_item.submit;
    assign cur_b     = r_stage ? r_item.stop  : r_item.start;
    assign cur_ins   = r_stage ? r_item.ins_exec : r_item.ins_start;
    assign cur_count = r_stage ? r_count_e : r_count_s;
    assign overlap   = (r_rd_hi >= cur_a) && (r_rd_lo <= cur_b);
    assign adv_state = !r_stage ? S_SETUP : (r_item.last ? S_SUM_SETUP : S_IDLE);
    assign load_out  = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_stage     = r_stage;
        n_count_s   = r_count_s;
        n_count_e   = r_count_e;
        n_n         = r_n;
        n_i         = r_i;
        n_w         = r_w;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_hit       = r_hit;
        n_rdv       = 1'b0;
        n_dv        = 1'b0;
        n_diff      = r_rd_hi - r_rd_lo;
        n_acc_s     = r_acc_s;
        n_acc_e     = r_acc_e;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_s     = r_out_s;
        n_out_e     = r_out_e;
        n_out_ovf   = r_out_ovf;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = {r_stage, r_i[IW-1:0]};
        mem_waddr   = {r_stage, r_w[IW-1:0]};
        mem_wlo     = r_rd_lo;
        mem_whi     = r_rd_hi;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_stage = 1'b0;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_lo  = cur_a;
                n_hi  = cur_b;
                n_hit = 1'b0;
                n_i   = '0;
                n_w   = '0;
                n_n   = cur_count;
                if (cur_ins) begin
                    n_state = S_WALK;
                end else begin
                    n_state = adv_state;
                    n_stage = !r_stage;
                end
            end
            S_WALK: begin
                if (r_i < r_n) begin
                    mem_re = 1'b1;
                    n_rdv  = 1'b1;
                    n_i    = r_i + CW'(1);
                end
                // Absorb touching entries, compact the rest toward the bottom.
                if (r_rdv) begin
                    if (overlap) begin
                        n_hit = 1'b1;
                        if (r_rd_lo < r_lo) begin
                            n_lo = r_rd_lo;
                        end
                        if (r_rd_hi > r_hi) begin
                            n_hi = r_rd_hi;
                        end
                    end else begin
                        mem_we = 1'b1;
                        n_w    = r_w + CW'(1);
                    end
                end
                if ((r_i == r_n) && !r_rdv) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                if (!r_hit && (r_w >= MAX_CNT)) begin
                    n_ovf = 1'b1;
                end else begin
                    mem_we  = 1'b1;
                    mem_wlo = r_lo;
                    mem_whi = r_hi;
                    if (r_stage) begin
                        n_count_e = r_w + CW'(1);
                    end else begin
                        n_count_s = r_w + CW'(1);
                    end
                end
                n_state = adv_state;
                n_stage = !r_stage;
            end
            S_SUM_SETUP: begin
                n_i = '0;
                n_n = cur_count;
                if (!r_stage) begin
                    n_acc_s = '0;
                    n_acc_e = '0;
                end
                n_state = S_SUM;
            end
            S_SUM: begin
                if (r_i < r_n) begin
                    mem_re = 1'b1;
                    n_rdv  = 1'b1;
                    n_i    = r_i + CW'(1);
                end
                n_dv = r_rdv;
                if (r_dv) begin
                    if (r_stage) begin
                        n_acc_e = r_acc_e + r_diff;
                    end else begin
                        n_acc_s = r_acc_s + r_diff;
                    end
                end
                if ((r_i == r_n) && !r_rdv && !r_dv) begin
                    if (!r_stage) begin
                        n_stage = 1'b1;
                        n_state = S_SUM_SETUP;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                // Hold until the output register is free, then clear the batch.
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_out_s     = r_acc_s;
                    n_out_e     = r_acc_e;
                    n_out_ovf   = r_ovf;
                    n_count_s   = '0;
                    n_count_e   = '0;
                    n_ovf       = 1'b0;
                    n_stage     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= 1'b0;
            r_count_s   <= '0;
            r_count_e   <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_w         <= '0;
            r_hit       <= 1'b0;
            r_rdv       <= 1'b0;
            r_dv        <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_count_s   <= n_count_s;
            r_count_e   <= n_count_e;
            r_n         <= n_n;
            r_i         <= n_i;
            r_w         <= n_w;
            r_hit       <= n_hit;
            r_rdv       <= n_rdv;
            r_dv        <= n_dv;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_item    <= n_item;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_diff    <= n_diff;
        r_acc_s   <= n_acc_s;
        r_acc_e   <= n_acc_e;
        r_out_s   <= n_out_s;
        r_out_e   <= n_out_e;
        r_out_ovf <= n_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_lo[mem_waddr] <= mem_wlo;
            m_hi[mem_waddr] <= mem_whi;
        end
        if (mem_re) begin
            r_rd_lo <= m_lo[mem_raddr];
            r_rd_hi <= m_hi[mem_raddr];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_starting_total  = r_out_s;
    assign o_executing_total = r_out_e;
    assign o_table_overflow  = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count_s <= MAX_CNT) && (r_count_e <= MAX_CNT))
        else $error("table count exceeds capacity");

    a_compact_below_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_rdv && !overlap) |-> (r_w < r_i))
        else $error("compaction write overtakes the walk");

    a_batch_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_out_valid && r_count_s == '0 && r_count_e == '0 && !r_ovf))
        else $error("batch not cleared after result load");

endmodule

// ===== sv/busy_time_interval_union.sv =====
// Merge: a command walks the tables in the merge unit, reading each of the N_s and N_e
// entries of its two tables once (a stage with nothing to insert is skipped); the single
// table memory read port paces this walk. A last beat adds a summation walk over both tables.
// Throughput: one command per merge pass; a two-entry queue takes beats meanwhile.
// Reset: tables count as empty and the overflow flag clears; table memory is not cleared.
module busy_time_interval_union #(
    parameter int MAX_INTERVALS = btiu_pkg::MAX_INTERVALS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  btiu_pkg::t_time  i_submit_time,
    input  btiu_pkg::t_time  i_start_time,
    input  btiu_pkg::t_time  i_end_time,
    input  logic             i_profiled,
    input  logic             i_last_event,
    output logic             o_valid,
    input  logic             i_ready,
    output btiu_pkg::t_time  o_starting_total,
    output btiu_pkg::t_time  o_executing_total,
    output logic             o_table_overflow
);

    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    btiu_pkg::t_item q_in;
    btiu_pkg::t_item q_out;

    btiu_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_submit_time (i_submit_time),
        .i_start_time  (i_start_time),
        .i_end_time    (i_end_time),
        .i_profiled    (i_profiled),
        .i_last_event  (i_last_event),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_item        (q_in)
    );

    btiu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out)
    );

    btiu_back #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (q_empty),
        .i_item            (q_out),
        .o_pop             (q_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_starting_total  (o_starting_total),
        .o_executing_total (o_executing_total),
        .o_table_overflow  (o_table_overflow)
    );

endmodule

// ===== tb/tb_busy_time_interval_union.sv =====
// Self-checking testbench for the busy-time interval union block.
`timescale 1ns / 100ps

module tb_busy_time_interval_union;

    typedef btiu_pkg::t_time t_time;

    localparam int    MAX_INTERVALS = btiu_pkg::MAX_INTERVALS;
    localparam int    HALF_PERIOD  = 5;
    localparam int    LONG_HOLD    = 500;
    localparam int    SETTLE_WAIT  = 4 * (MAX_INTERVALS + 3) + 20;
    localparam int    CYCLE_LIMIT  = 1000000;
    localparam int    RANDOM_ITEMS = 850;
    localparam t_time ALL_ONES     = '1;

    typedef struct {
        t_time submit;
        t_time start;
        t_time stop;
        logic  profiled;
        logic  last;
        bit    drain_first;   // wait for all totals before offering this beat
        bit    hold_sink;     // ask the receiver for a long hold-off
    } t_cmd;

    typedef struct {
        t_time starting;
        t_time executing;
        logic  overflow;
    } t_totals;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_time i_submit_time = '0;
    t_time i_start_time = '0;
    t_time i_end_time = '0;
    logic  i_profiled = 1'b0;
    logic  i_last_event = 1'b0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_time o_starting_total;
    t_time o_executing_total;
    logic  o_table_overflow;

    busy_time_interval_union u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_submit_time    (i_submit_time),
        .i_start_time     (i_start_time),
        .i_end_time       (i_end_time),
        .i_profiled       (i_profiled),
        .i_last_event     (i_last_event),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_starting_total (o_starting_total),
        .o_executing_total(o_executing_total),
        .o_table_overflow (o_table_overflow)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_cmd    cmd_queue[$];
    t_totals expected_totals[$];
    int      mismatches = 0;
    int      cycle_cnt = 0;
    int      send_gap = 0;
    int      sink_stall = 0;
    int      sink_hold = 0;
    int      hold_req = 0;
    int      hold_served = 0;
    logic    in_taken = 1'b0;
    logic    out_taken = 1'b0;

    // Shadow interval tables: index 0 is the starting stage, 1 the executing stage.
    t_time       span_lo[2][MAX_INTERVALS];
    t_time       span_hi[2][MAX_INTERVALS];
    int unsigned span_cnt[2] = '{0, 0};
    bit          span_dropped = 1'b0;

    task automatic merge_span(input int s, input t_time a, input t_time b);
        int unsigned w;
        t_time       lo;
        t_time       hi;
        bit          hit;
        w   = 0;
        lo  = a;
        hi  = b;
        hit = 1'b0;
        if (b < a) return;
        for (int i = 0; i < span_cnt[s]; i++)
            if (span_lo[s][i] == a && span_hi[s][i] == b) return;
        // Fold every entry that overlaps or touches; compact the rest downward.
        for (int i = 0; i < span_cnt[s]; i++) begin
            if (span_hi[s][i] >= a && span_lo[s][i] <= b) begin
                hit = 1'b1;
                if (span_lo[s][i] < lo) lo = span_lo[s][i];
                if (span_hi[s][i] > hi) hi = span_hi[s][i];
            end else begin
                span_lo[s][w] = span_lo[s][i];
                span_hi[s][w] = span_hi[s][i];
                w++;
            end
        end
        if (!hit && w >= MAX_INTERVALS) begin
            span_dropped = 1'b1;
            return;
        end
        span_lo[s][w] = lo;
        span_hi[s][w] = hi;
        span_cnt[s]   = w + 1;
    endtask

    task automatic take_command(input t_time sub, input t_time sta, input t_time sto,
                                input logic prof, input logic last);
        t_totals t;
        if (prof) begin
            merge_span(0, sub, sta);
            merge_span(1, sta, sto);
        end
        if (last) begin
            t.starting  = '0;
            t.executing = '0;
            for (int i = 0; i < span_cnt[0]; i++)
                t.starting += span_hi[0][i] - span_lo[0][i];
            for (int i = 0; i < span_cnt[1]; i++)
                t.executing += span_hi[1][i] - span_lo[1][i];
            t.overflow = span_dropped;
            expected_totals = {expected_totals, t};
            span_cnt[0]  = 0;
            span_cnt[1]  = 0;
            span_dropped = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        // Keep some stretches fully back to back.
        if (cycle_cnt % 4096 < 1024) return 0;
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic t_time rand_time();
        return {$urandom, $urandom};
    endfunction

    task automatic add_cmd(input t_time sub, input t_time sta, input t_time sto,
                           input logic prof, input logic last,
                           input bit drain = 1'b0, input bit hold = 1'b0);
        t_cmd c;
        c.submit      = sub;
        c.start       = sta;
        c.stop        = sto;
        c.profiled    = prof;
        c.last        = last;
        c.drain_first = drain;
        c.hold_sink   = hold;
        cmd_queue = {cmd_queue, c};
    endtask

    task automatic add_directed();
        // Widest possible interval in one stage, empty one in the other.
        add_cmd('0, ALL_ONES, ALL_ONES, 1'b1, 1'b1);
        // Identical intervals, then a last beat that is not profiled.
        add_cmd(100, 150, 300, 1'b1, 1'b0);
        add_cmd(100, 150, 300, 1'b1, 1'b0);
        add_cmd(100, 150, 300, 1'b0, 1'b1);
        // Inverted intervals in each stage.
        add_cmd(500, 400, 450, 1'b1, 1'b0);
        add_cmd(10, 20, 15, 1'b1, 1'b1);
        // One interval folding several entries at once.
        add_cmd(0, 5, 10, 1'b1, 1'b0);
        add_cmd(20, 25, 30, 1'b1, 1'b0);
        add_cmd(40, 45, 50, 1'b1, 1'b0);
        add_cmd(3, 42, 48, 1'b1, 1'b1);
        // One more disjoint interval than the table holds: the last one finds it full.
        for (int i = 0; i < MAX_INTERVALS + 1; i++)
            add_cmd(t_time'(i * 100), t_time'(i * 100 + 10), t_time'(i * 100 + 20),
                    1'b1, i == MAX_INTERVALS);
        // Overflow must clear for the next batch.
        add_cmd(0, 1, 2, 1'b1, 1'b1, 1'b1);
    endtask

    // Sort-free batch builder: most modes draw a batch from one time window so intervals collide.
    task automatic add_batch(input int len, input bit drain, input bit all_last, inout int made);
        int    mode;
        int    win;
        int    dmax;
        int    r;
        t_time base;
        t_time s;
        t_time st;
        t_time e;
        t_time tmp;
        t_time ps;
        t_time pst;
        t_time pe;
        bit    have_prev;
        logic  prof;
        mode      = $urandom_range(0, 3);
        win       = (mode == 1) ? (1 << 20) : 300;
        dmax      = (mode == 1) ? 400 : 40;
        have_prev = 1'b0;
        base      = rand_time();
        if (mode == 3) base = $urandom_range(0, 1) ? t_time'(0) : ALL_ONES - 400;
        else if (base > ALL_ONES - (1 << 21)) base -= t_time'(1 << 21);
        for (int k = 0; k < len; k++) begin
            if (mode == 2) begin
                s  = rand_time();
                st = rand_time();
                e  = rand_time();
                if ($urandom_range(0, 9) < 6) begin
                    if (st < s) begin tmp = s; s = st; st = tmp; end
                    if (e < st) begin tmp = st; st = e; e = tmp; end
                    if (st < s) begin tmp = s; s = st; st = tmp; end
                end
            end else begin
                s  = base + t_time'($urandom_range(0, win));
                st = s + t_time'($urandom_range(0, dmax));
                e  = st + t_time'($urandom_range(0, dmax));
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                tmp = s; s = st; st = tmp;
            end else if (r < 6) begin
                tmp = st; st = e; e = tmp;
            end else if (r < 12 && have_prev) begin
                s = ps; st = pst; e = pe;
            end
            prof = ($urandom_range(0, 99) >= 8);
            add_cmd(s, st, e, prof, all_last || k == len - 1, drain && k == 0);
            ps        = s;
            pst       = st;
            pe        = e;
            have_prev = 1'b1;
            made++;
        end
    endtask

    task automatic add_random();
        int  made;
        int  len;
        int  r;
        bit  burst_done;
        made       = 0;
        burst_done = 1'b0;
        while (made < RANDOM_ITEMS) begin
            if (!burst_done && made >= RANDOM_ITEMS / 2) begin
                // Many totals in a row while the receiver holds off.
                add_cmd(rand_time(), rand_time(), rand_time(), 1'b1, 1'b1, 1'b0, 1'b1);
                add_batch(20, 1'b0, 1'b1, made);
                burst_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 12);
            else if (r < 90) len = $urandom_range(13, 24);
            else len = $urandom_range(25, 40);
            add_batch(len, made == 0 || $urandom_range(0, 99) < 3, 1'b0, made);
        end
    endtask

    // Sender: present beats at the falling edge.
    always @(negedge i_clk) begin : sender
        t_cmd c;
        if (i_rst_n) begin
            if (i_valid && !in_taken) begin
                // hold the beat until it is taken
            end else if (send_gap > 0) begin
                i_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (cmd_queue.size() > 0 &&
                         !(cmd_queue[0].drain_first && expected_totals.size() != 0)) begin
                c = cmd_queue.pop_front();
                i_submit_time <= c.submit;
                i_start_time  <= c.start;
                i_end_time    <= c.stop;
                i_profiled    <= c.profiled;
                i_last_event  <= c.last;
                i_valid       <= 1'b1;
                if (c.hold_sink) hold_req <= hold_req + 1;
                send_gap <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: drive ready at the falling edge.
    always @(negedge i_clk) begin : receiver
        if (i_rst_n) begin
            if (hold_served != hold_req) begin
                hold_served <= hold_served + 1;
                sink_hold   <= LONG_HOLD;
                i_ready     <= 1'b0;
            end else if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                i_ready   <= 1'b0;
            end else if (out_taken) begin
                sink_stall = pick_gap();
                i_ready <= (sink_stall == 0);
            end else if (sink_stall > 0) begin
                sink_stall = sink_stall - 1;
                i_ready <= (sink_stall == 0);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: sample both channels at the rising edge.
    always @(posedge i_clk) begin : watcher
        t_totals want;
        in_taken  <= i_valid && o_ready;
        out_taken <= o_valid && i_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                take_command(i_submit_time, i_start_time, i_end_time,
                             i_profiled, i_last_event);
            if (o_valid && i_ready) begin
                if (expected_totals.size() == 0) begin
                    $error("result beat with nothing expected: starting_total=%0d",
                           o_starting_total);
                    mismatches++;
                end else begin
                    want = expected_totals.pop_front();
                    if (o_starting_total !== want.starting) begin
                        $error("starting_total: expected %0d, got %0d",
                               want.starting, o_starting_total);
                        mismatches++;
                    end
                    if (o_executing_total !== want.executing) begin
                        $error("executing_total: expected %0d, got %0d",
                               want.executing, o_executing_total);
                        mismatches++;
                    end
                    if (o_table_overflow !== want.overflow) begin
                        $error("table_overflow: expected %0d, got %0d",
                               want.overflow, o_table_overflow);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        add_directed();
        add_random();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        while (cmd_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/btiu_pkg.sv
sv/btiu_front.sv
sv/btiu_queue.sv
sv/btiu_back.sv
sv/busy_time_interval_union.sv
tb/tb_busy_time_interval_union.sv
